// ===== hw/rtl/fcsg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fcsg_pkg: shared types and constants for the filled circle span generator
// Transaction payloads, configuration register indexes and fixed limits.
// ----------------------------------------------------------------------------
package fcsg_pkg;

    localparam int unsigned COORD_W  = 12;
    localparam int unsigned RADIUS_W = 6;
    localparam int unsigned COLOUR_W = 32;
    localparam int unsigned DIM_W    = 13;
    localparam int unsigned DEC_W    = 10;   // midpoint decision value, signed

    localparam logic [RADIUS_W-1:0] MAX_RADIUS   = 6'd40;
    localparam logic [DIM_W-1:0]    FRAME_LIMIT  = 13'd4096;
    localparam logic [DIM_W-1:0]    WIDTH_RESET  = 13'd640;
    localparam logic [DIM_W-1:0]    HEIGHT_RESET = 13'd480;

    typedef enum logic [0:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } cfg_index_t;

    typedef struct packed {
        cfg_index_t         index;
        logic [DIM_W-1:0]   value;
    } cfg_wr_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] centre_x;
        logic signed [COORD_W-1:0] centre_y;
        logic [RADIUS_W-1:0]       radius;
        logic [COLOUR_W-1:0]       fill_colour;
    } circle_t;

    typedef struct packed {
        logic [COORD_W-1:0]  span_start;
        logic [COORD_W-1:0]  span_end;
        logic [COORD_W-1:0]  upper_row;
        logic [COORD_W-1:0]  lower_row;
        logic                upper_visible;
        logic                lower_visible;
        logic [COLOUR_W-1:0] span_colour;
        logic                last_span;
    } span_t;

    // request to the clip unit: half width h around cx, rows cy-v and cy+v
    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic [RADIUS_W-1:0]       h;
        logic [RADIUS_W-1:0]       v;
        logic                      pair;
    } clip_req_t;

    typedef struct packed {
        logic [COORD_W-1:0] span_start;
        logic [COORD_W-1:0] span_end;
        logic [COORD_W-1:0] upper_row;
        logic [COORD_W-1:0] lower_row;
        logic               upper_visible;
        logic               lower_visible;
    } clip_res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/fcsg_ifs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fcsg_ifs: valid/ready channels of the filled circle span generator
// Configuration write, circle request and span result channels.
// ----------------------------------------------------------------------------
interface fcsg_cfg_if;
    logic             valid;
    logic             ready;
    fcsg_pkg::cfg_wr_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fcsg_circle_if;
    logic              valid;
    logic              ready;
    fcsg_pkg::circle_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fcsg_span_if;
    logic            valid;
    logic            ready;
    fcsg_pkg::span_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/fcsg_span_clip.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fcsg_span_clip: shared span clip unit
// Forms [cx-h, cx+h] at rows cy-v and cy+v, clips to the frame, flags rows.
// ----------------------------------------------------------------------------
module fcsg_span_clip (
    input  fcsg_pkg::clip_req_t         req,
    input  logic [fcsg_pkg::DIM_W-1:0]  frame_width,
    input  logic [fcsg_pkg::DIM_W-1:0]  frame_height,
    output fcsg_pkg::clip_res_t         res
);

    logic signed [13:0] cx_ext;
    logic signed [13:0] cy_ext;
    logic signed [13:0] h_ext;
    logic signed [13:0] v_ext;
    logic signed [13:0] left;
    logic signed [13:0] right;
    logic signed [13:0] up;
    logic signed [13:0] down;
    logic signed [13:0] col_max;
    logic signed [13:0] row_lim;
    logic signed [13:0] lo;
    logic signed [13:0] hi;
    logic               span_ok;
    logic               up_ok;
    logic               down_ok;

    always_comb
    begin
        cx_ext  = signed'({{2{req.cx[11]}}, req.cx});
        cy_ext  = signed'({{2{req.cy[11]}}, req.cy});
        h_ext   = signed'({8'b0, req.h});
        v_ext   = signed'({8'b0, req.v});
        left    = cx_ext - h_ext;
        right   = cx_ext + h_ext;
        up      = cy_ext - v_ext;
        down    = cy_ext + v_ext;
        col_max = signed'({1'b0, frame_width}) - 14'sd1;
        row_lim = signed'({1'b0, frame_height});

        lo      = (left < 14'sd0) ? 14'sd0 : left;
        hi      = (right > col_max) ? col_max : right;
        span_ok = (lo <= hi);
        up_ok   = span_ok && (up >= 14'sd0) && (up < row_lim);
        down_ok = req.pair && span_ok && (down >= 14'sd0) && (down < row_lim);

        res.span_start    = span_ok ? lo[11:0] : 12'd0;
        res.span_end      = span_ok ? hi[11:0] : 12'd0;
        res.upper_row     = up_ok ? up[11:0] : 12'd0;
        res.lower_row     = down_ok ? down[11:0] : 12'd0;
        res.upper_visible = up_ok;
        res.lower_visible = down_ok;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/filled_circle_span_generator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// filled_circle_span_generator: midpoint circle fill span generator
// Turns one circle request into a stream of clipped horizontal fill spans.
// ----------------------------------------------------------------------------
// Usage
//   cfg    : register writes (index 0 frame width, index 1 frame height).
//            Always ready; values above 4096 are stored as 4096. Write only
//            while no circle is in flight.
//   circle : one transaction per circle (centre, radius, colour). Ready only
//            while the sequencer is idle; radius saturates at 40.
//   span   : the centre row first, then two span pairs per midpoint step.
//            last_span marks the final transaction of a circle.
// Flow
//   The circle transaction moves the sequencer to its centre state, which
//   loads the first span into the output register. The sequencer drives a
//   single shared clip unit and issues the spans one after another, and
//   ready rises again as the last span is loaded into the output register.
//   A stalled span receiver holds the output register and the sequencer
//   waits with it; nothing is dropped.
// Reset
//   rst_n clears the sequencer and output valid, frame width to 640 and
//   height to 480.
// ----------------------------------------------------------------------------
module filled_circle_span_generator (
    input  wire logic            clk,
    input  wire logic            rst_n,
    fcsg_cfg_if.sink             cfg,
    fcsg_circle_if.sink          circle,
    fcsg_span_if.source          span
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_CENTRE = 4'b0010,
        S_EMIT_A = 4'b0100,
        S_EMIT_B = 4'b1000
    } state_t;

    state_t                                 state_reg, state_next;
    logic [fcsg_pkg::DIM_W-1:0]             frame_width_reg, frame_width_next;
    logic [fcsg_pkg::DIM_W-1:0]             frame_height_reg, frame_height_next;

    // circle context and midpoint iteration registers
    logic signed [fcsg_pkg::COORD_W-1:0]    cx_reg;
    logic signed [fcsg_pkg::COORD_W-1:0]    cy_reg;
    logic [fcsg_pkg::COLOUR_W-1:0]          colour_reg;
    logic [fcsg_pkg::RADIUS_W-1:0]          x_reg, x_next;
    logic [fcsg_pkg::RADIUS_W-1:0]          y_reg, y_next;
    logic signed [fcsg_pkg::DEC_W-1:0]      p_reg, p_next;

    fcsg_pkg::span_t                        out_reg, out_next;
    logic                                   out_valid_reg, out_valid_next;

    logic                                   accept;
    logic                                   out_free;
    logic                                   emit;
    logic                                   advance;
    logic [fcsg_pkg::RADIUS_W-1:0]          r_sat;
    logic [fcsg_pkg::RADIUS_W-1:0]          x_step;
    logic [fcsg_pkg::RADIUS_W-1:0]          y_step;
    logic signed [fcsg_pkg::DEC_W-1:0]      p_step;
    logic signed [fcsg_pkg::DEC_W-1:0]      two_y;
    logic signed [fcsg_pkg::DEC_W-1:0]      two_x;
    logic                                   step_last;
    logic                                   span_last;
    fcsg_pkg::clip_req_t                    clip_req;
    fcsg_pkg::clip_res_t                    clip_res;

    assign cfg.ready    = 1'b1;
    assign circle.ready = (state_reg == S_IDLE);
    assign span.valid   = out_valid_reg;
    assign span.data    = out_reg;

    assign accept   = circle.valid && circle.ready;
    assign out_free = !out_valid_reg || span.ready;
    assign r_sat    = (circle.data.radius > fcsg_pkg::MAX_RADIUS) ?
                      fcsg_pkg::MAX_RADIUS : circle.data.radius;

    // one midpoint step from (x_reg, y_reg, p_reg)
    always_comb
    begin
        y_step = y_reg + 6'd1;
        two_y  = signed'({3'b000, y_step, 1'b0});
        if (p_reg <= 10'sd0)
        begin
            x_step = x_reg;
            two_x  = 10'sd0;
        end
        else
        begin
            x_step = x_reg - 6'd1;
            two_x  = signed'({3'b000, x_step, 1'b0});
        end
        p_step = p_reg + two_y - two_x + 10'sd1;
        // loop ends when x no longer exceeds y, or the step crosses the octant
        step_last = !(x_reg > y_reg) || (x_step < y_step);
    end

    // operand select for the shared clip unit
    always_comb
    begin
        clip_req.cx = cx_reg;
        clip_req.cy = cy_reg;
        unique case (state_reg)
            S_CENTRE:
            begin
                clip_req.h    = x_reg;
                clip_req.v    = '0;
                clip_req.pair = 1'b0;
            end
            S_EMIT_B:
            begin
                clip_req.h    = y_reg;
                clip_req.v    = x_reg;
                clip_req.pair = 1'b1;
            end
            default:
            begin
                clip_req.h    = x_reg;
                clip_req.v    = y_reg;
                clip_req.pair = 1'b1;
            end
        endcase
    end

    fcsg_span_clip u_clip (
        .req          (clip_req),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .res          (clip_res)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        emit       = 1'b0;
        advance    = 1'b0;
        span_last  = 1'b0;
        unique case (state_reg) inside
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_CENTRE;
                end
            end
            S_CENTRE, S_EMIT_B:
            begin
                span_last = step_last;
                if (out_free)
                begin
                    emit    = 1'b1;
                    advance = !step_last;
                    state_next = step_last ? S_IDLE : S_EMIT_A;
                end
            end
            S_EMIT_A:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = S_EMIT_B;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        p_next = p_reg;
        if (accept)
        begin
            x_next = r_sat;
            y_next = '0;
            p_next = 10'sd1 - signed'({4'b0000, r_sat});
        end
        else if (advance)
        begin
            x_next = x_step;
            y_next = y_step;
            p_next = p_step;
        end
    end

    always_comb
    begin
        out_next                = out_reg;
        out_valid_next          = out_valid_reg;
        if (emit)
        begin
            out_next.span_start    = clip_res.span_start;
            out_next.span_end      = clip_res.span_end;
            out_next.upper_row     = clip_res.upper_row;
            out_next.lower_row     = clip_res.lower_row;
            out_next.upper_visible = clip_res.upper_visible;
            out_next.lower_visible = clip_res.lower_visible;
            out_next.span_colour   = colour_reg;
            out_next.last_span     = span_last;
            out_valid_next         = 1'b1;
        end
        else if (span.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // configuration writes, saturated to the frame limit
    always_comb
    begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        if (cfg.valid)
        begin
            unique case (cfg.data.index)
                fcsg_pkg::CFG_FRAME_WIDTH:
                begin
                    frame_width_next = (cfg.data.value > fcsg_pkg::FRAME_LIMIT) ?
                                       fcsg_pkg::FRAME_LIMIT : cfg.data.value;
                end
                fcsg_pkg::CFG_FRAME_HEIGHT:
                begin
                    frame_height_next = (cfg.data.value > fcsg_pkg::FRAME_LIMIT) ?
                                        fcsg_pkg::FRAME_LIMIT : cfg.data.value;
                end
                default:
                begin
                    frame_width_next = frame_width_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            out_valid_reg    <= 1'b0;
            frame_width_reg  <= fcsg_pkg::WIDTH_RESET;
            frame_height_reg <= fcsg_pkg::HEIGHT_RESET;
        end
        else
        begin
            state_reg        <= state_next;
            out_valid_reg    <= out_valid_next;
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cx_reg     <= circle.data.centre_x;
            cy_reg     <= circle.data.centre_y;
            colour_reg <= circle.data.fill_colour;
        end
        x_reg   <= x_next;
        y_reg   <= y_next;
        p_reg   <= p_next;
        out_reg <= out_next;
    end

`ifndef SYNTHESIS
    // the first half of a step never sees y beyond x
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT_A) |-> (y_reg <= x_reg))
        else $error("midpoint step crossed the octant");

    // a busy sequencer never holds a radius above the limit
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (x_reg <= fcsg_pkg::MAX_RADIUS))
        else $error("iteration x out of range");

    // behind a pending last span only the next circle's centre can wait
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.last_span) |->
            (state_reg == S_IDLE || state_reg == S_CENTRE))
        else $error("last span issued while circle still in progress");
`endif

endmodule
`default_nettype wire

// ===== tb/tb_filled_circle_span_generator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_filled_circle_span_generator: self-checking bench for the span generator
// Sends circle transactions and predicts the clipped midpoint fill spans of
// each one. Every span transaction is checked field by field against the
// oldest prediction. Frame registers are rewritten between idle phases, and
// both channel ends idle and stall at random.
// ----------------------------------------------------------------------------
module tb_filled_circle_span_generator;

    import fcsg_pkg::*;

    localparam int CLK_HALF         = 4;
    localparam int RESET_CYCLES     = 9;
    localparam int SPAN_LIMIT       = 64;      // cap on spans predicted per circle, above the most one can give
    localparam int DRAIN_CYCLES     = 4;       // extra wait after the last span is taken
    localparam int RANDOM_PER_PHASE = 58;
    localparam int WATCHDOG_CYCLES  = 1000000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    fcsg_cfg_if    cfg_ch ();
    fcsg_circle_if circle_ch ();
    fcsg_span_if   span_ch ();

    filled_circle_span_generator i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .circle (circle_ch),
        .span   (span_ch)
    );

    // frame registers as the block should hold them
    logic [DIM_W-1:0] frame_w;
    logic [DIM_W-1:0] frame_h;

    // spans predicted for accepted circles, oldest first
    span_t expected_spans[$];

    int errors         = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Span prediction
    // ------------------------------------------------------------------------

    // register values past the frame limit behave as the limit
    function automatic int dim_limit(logic [DIM_W-1:0] v);
        return (v > FRAME_LIMIT) ? int'(FRAME_LIMIT) : int'(v);
    endfunction

    // clip [left,right] to the frame columns and rows up/down to the frame rows;
    // the centre span has no lower row (pair = 0)
    function automatic span_t clip_span(int left, int right, int up, int down,
                                        bit pair, logic [COLOUR_W-1:0] colour);
        span_t s;
        int    w;
        int    h;
        int    lo;
        int    hi;
        bit    span_ok;
        bit    up_ok;
        bit    down_ok;
        w       = dim_limit(frame_w);
        h       = dim_limit(frame_h);
        lo      = (left < 0) ? 0 : left;
        hi      = (right > w - 1) ? w - 1 : right;
        span_ok = (lo <= hi);
        up_ok   = span_ok && up >= 0 && up < h;
        down_ok = pair && span_ok && down >= 0 && down < h;
        s               = '0;
        s.span_start    = span_ok ? COORD_W'(lo) : '0;
        s.span_end      = span_ok ? COORD_W'(hi) : '0;
        s.upper_row     = up_ok ? COORD_W'(up) : '0;
        s.lower_row     = down_ok ? COORD_W'(down) : '0;
        s.upper_visible = up_ok;
        s.lower_visible = down_ok;
        s.span_colour   = colour;
        return s;
    endfunction

    // midpoint circle walk from (r,0); each step yields the x-wide pair and
    // then the y-wide pair, stopping once y passes x
    function automatic void predict_circle_spans(circle_t c);
        span_t spans[$];
        int    cx;
        int    cy;
        int    r;
        int    x;
        int    y;
        int    p;
        cx = int'($signed(c.centre_x));
        cy = int'($signed(c.centre_y));
        r  = (c.radius > MAX_RADIUS) ? int'(MAX_RADIUS) : int'(c.radius);
        spans.push_back(clip_span(cx - r, cx + r, cy, 0, 1'b0, c.fill_colour));
        x = r;
        y = 0;
        p = 1 - r;
        while (x > y && spans.size() + 2 <= SPAN_LIMIT)
        begin
            y = y + 1;
            if (p <= 0)
                p = p + 2 * y + 1;
            else
            begin
                x = x - 1;
                p = p + 2 * y - 2 * x + 1;
            end
            if (x < y)
                break;
            spans.push_back(clip_span(cx - x, cx + x, cy - y, cy + y, 1'b1, c.fill_colour));
            spans.push_back(clip_span(cx - y, cx + y, cy - x, cy + x, 1'b1, c.fill_colour));
        end
        spans[spans.size() - 1].last_span = 1'b1;
        foreach (spans[i])
            expected_spans.push_back(spans[i]);
    endfunction

    // ------------------------------------------------------------------------
    // Span receiver and checker
    // ------------------------------------------------------------------------

    // ready is redrawn each cycle, so stalls land anywhere in a circle
    always @(posedge clk)
    begin
        if (!rst_n)
            span_ch.ready <= 1'b0;
        else
            span_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic void check_field(string name, logic [COLOUR_W-1:0] exp_val,
                                        logic [COLOUR_W-1:0] got_val);
        if (got_val !== exp_val)
        begin
            errors++;
            $display("%0t: span %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, exp_val, got_val);
        end
    endfunction

    always @(posedge clk)
    begin : span_check
        span_t exp_span;
        span_t got;
        if (rst_n && span_ch.valid && span_ch.ready)
        begin
            got = span_ch.data;
            if (expected_spans.size() == 0)
            begin
                errors++;
                $display("%0t: span transaction with nothing expected, expected none, actual %p",
                         $time, got);
            end
            else
            begin
                exp_span = expected_spans.pop_front();
                check_field("span_start",    COLOUR_W'(exp_span.span_start),
                            COLOUR_W'(got.span_start));
                check_field("span_end",      COLOUR_W'(exp_span.span_end),
                            COLOUR_W'(got.span_end));
                check_field("upper_row",     COLOUR_W'(exp_span.upper_row),
                            COLOUR_W'(got.upper_row));
                check_field("lower_row",     COLOUR_W'(exp_span.lower_row),
                            COLOUR_W'(got.lower_row));
                check_field("upper_visible", COLOUR_W'(exp_span.upper_visible),
                            COLOUR_W'(got.upper_visible));
                check_field("lower_visible", COLOUR_W'(exp_span.lower_visible),
                            COLOUR_W'(got.lower_visible));
                check_field("span_colour",   exp_span.span_colour,   got.span_colour);
                check_field("last_span",     COLOUR_W'(exp_span.last_span),
                            COLOUR_W'(got.last_span));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drivers; every task starts and ends on a rising edge
    // ------------------------------------------------------------------------

    // one circle transaction; valid is left high so back-to-back sends need
    // no second assignment in the same step
    task automatic send_circle(circle_t c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            circle_ch.valid <= 1'b0;
            @(posedge clk);
        end
        circle_ch.valid <= 1'b1;
        circle_ch.data  <= c;
        @(posedge clk);
        while (!circle_ch.ready)
            @(posedge clk);
        predict_circle_spans(c);
    endtask

    // drop valid and let every predicted span come out
    task automatic wait_idle();
        circle_ch.valid <= 1'b0;
        while (expected_spans.size() != 0)
            @(posedge clk);
        // the sequencer is already idle once the last span is taken; then pad with DRAIN_CYCLES
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    // width then height, valid held across both writes; only when idle
    task automatic set_frame(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
        cfg_wr_t wr;
        wait_idle();
        wr.index = CFG_FRAME_WIDTH;
        wr.value = w;
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= wr;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        frame_w  = w;
        wr.index = CFG_FRAME_HEIGHT;
        wr.value = h;
        cfg_ch.data <= wr;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        frame_h = h;
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic circle_t make_circle(int cx, int cy, int r, logic [COLOUR_W-1:0] colour);
        circle_t c;
        c.centre_x    = COORD_W'(cx);
        c.centre_y    = COORD_W'(cy);
        c.radius      = RADIUS_W'(r);
        c.fill_colour = colour;
        return c;
    endfunction

    // mostly near the frame so clipping is exercised, sometimes anywhere;
    // radius mostly in range, sometimes past the saturation point
    function automatic circle_t random_circle();
        circle_t c;
        int      lim_x;
        int      lim_y;
        lim_x = (dim_limit(frame_w) > 2047) ? 2047 : dim_limit(frame_w);
        lim_y = (dim_limit(frame_h) > 2047) ? 2047 : dim_limit(frame_h);
        if ($urandom_range(4) != 0)
        begin
            c.centre_x = COORD_W'(int'($urandom_range(lim_x + 120)) - 60);
            c.centre_y = COORD_W'(int'($urandom_range(lim_y + 120)) - 60);
        end
        else
        begin
            c.centre_x = COORD_W'($urandom());
            c.centre_y = COORD_W'($urandom());
        end
        if ($urandom_range(6) != 0)
            c.radius = RADIUS_W'($urandom_range(int'(MAX_RADIUS)));
        else
            c.radius = RADIUS_W'($urandom_range(63, int'(MAX_RADIUS) + 1));
        c.fill_colour = $urandom();
        return c;
    endfunction

    function automatic logic [DIM_W-1:0] random_dim();
        case ($urandom_range(3))
            0:       return DIM_W'($urandom_range(64, 1));
            1:       return DIM_W'($urandom_range(700, 65));
            2:       return DIM_W'($urandom_range(4096, 701));
            default: return DIM_W'($urandom_range(8191));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // reset frame (640 x 480): radius extremes, saturation, single pixel
    task automatic test_radius_cases();
        send_circle(make_circle(100, 100, 0, 32'h0000_0000));
        send_circle(make_circle(320, 240, 1, 32'h1234_5678));
        send_circle(make_circle(320, 240, 2, 32'h8765_4321));
        send_circle(make_circle(200, 200, 7, 32'hA5A5_5A5A));
        send_circle(make_circle(320, 240, 40, 32'hFFFF_FFFF));
        send_circle(make_circle(320, 240, 41, 32'h5A5A_A5A5));
        send_circle(make_circle(320, 240, 63, 32'hDEAD_BEEF));
        wait_idle();
    endtask

    // circles crossing or missing every frame edge, centre field extremes
    task automatic test_clipping();
        send_circle(make_circle(-5, 5, 10, 32'h0F0F_0F0F));
        send_circle(make_circle(639, 479, 3, 32'hF0F0_F0F0));
        send_circle(make_circle(-2048, -2048, 40, 32'h0000_0001));
        send_circle(make_circle(2047, 2047, 40, 32'h8000_0000));
        send_circle(make_circle(-41, 100, 40, 32'h3333_3333));   // all spans left of frame
        send_circle(make_circle(660, 100, 20, 32'hCCCC_CCCC));   // all spans right of frame
        send_circle(make_circle(320, -10, 12, 32'h7777_7777));   // top rows cut
        send_circle(make_circle(320, 490, 12, 32'h9999_9999));   // bottom rows cut
        wait_idle();
    endtask

    // tiny, empty, oversized and limit frames
    task automatic test_frame_registers();
        set_frame(13'd1, 13'd1);
        send_circle(make_circle(0, 0, 5, 32'h1111_1111));
        set_frame(13'd0, 13'd0);                               // nothing visible
        send_circle(make_circle(0, 0, 3, 32'h2222_2222));
        set_frame(13'h1FFF, 13'd5000);                         // both act as 4096
        send_circle(make_circle(2047, 2047, 40, 32'h4444_4444));
        send_circle(make_circle(-20, -20, 40, 32'h6666_6666));
        set_frame(FRAME_LIMIT, FRAME_LIMIT);
        send_circle(make_circle(2047, 2047, 40, 32'h8888_8888));
        set_frame(13'd2048, 13'd2048);
        send_circle(make_circle(2040, 2040, 15, 32'hAAAA_AAAA));
        wait_idle();
    endtask

    // random circles over four idle/stall mixes, new random frame per phase
    task automatic test_random_traffic();
        int send_mix[4];
        int recv_mix[4];
        send_mix = '{0, 86, 0, 22};
        recv_mix = '{0, 0, 86, 22};
        for (int ph = 0; ph < 4; ph++)
        begin
            set_frame(random_dim(), random_dim());
            send_idle_pct  = send_mix[ph];
            recv_stall_pct = recv_mix[ph];
            repeat (RANDOM_PER_PHASE)
                send_circle(random_circle());
            wait_idle();
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial
    begin
        cfg_ch.valid    = 1'b0;
        cfg_ch.data     = '0;
        circle_ch.valid = 1'b0;
        circle_ch.data  = '0;
        frame_w         = WIDTH_RESET;
        frame_h         = HEIGHT_RESET;

        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_radius_cases();
        test_clipping();
        test_frame_registers();
        test_random_traffic();
        wait_idle();

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // watchdog: well beyond the slowest correct run
    initial
    begin
        #(WATCHDOG_CYCLES * 2 * CLK_HALF);
        $display("%0t: timeout, %0d spans still expected", $time, expected_spans.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
`default_nettype wire
